// File: hw/rtl/bounded_positional_list_macros.svh
// Assertion macros used by the checker file of the positional list.
`ifndef BOUNDED_POSITIONAL_LIST_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_MACROS_SVH

// A consequent that must hold in the same cycle as its antecedent.
`define BPL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define BPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bpl_pkg.sv
// Types, constants and helpers of the bounded positional list.
`timescale 1ns / 1ps

package bpl_pkg;

    localparam int CNT_W       = 9;
    localparam int VALUE_W     = 32;
    localparam int BYTES_W     = 16;
    localparam int ENTRY_W     = VALUE_W + BYTES_W;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [2:0] {
        MODE_INS_FIRST = 3'd0,
        MODE_INS_LAST  = 3'd1,
        MODE_INS_AT    = 3'd2,
        MODE_EXT_FIRST = 3'd3,
        MODE_EXT_LAST  = 3'd4,
        MODE_EXT_AT    = 3'd5,
        MODE_READ_AT   = 3'd6,
        MODE_CLEAR     = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_ZERO_BYTES = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ENTRY,
        ST_CAPTURE,
        ST_SHIFT,
        ST_INS_WR,
        ST_RESP
    } t_state;

    // A capacity of zero acts as one, and one above the store depth as the depth.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap,
                                                 input int max_entries);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if (int'(cap) > max_entries) begin
            res = CNT_W'(max_entries);
        end else begin
            res = cap;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/bpl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bpl_ram #(
    parameter int WIDTH = bpl_pkg::ENTRY_W,
    parameter int DEPTH = bpl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bounded_positional_list.sv
// Top level of the bounded positional list: sequencer around one entry RAM.
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  request   i_valid/o_ready, i_mode .. i_byte_count   in
//  result    o_valid/i_ready, o_status .. o_is_empty   out
//  config    i_cfg_we, i_cfg_data (list capacity)      in
//
// A request is taken only while the sequencer is idle. Errors, clear and appends
// go straight to the response; read at and extract of the last entry read and
// capture the entry first; other extracts then shift each later entry down, and
// other inserts shift each entry at or after the slot up, then write the new one.
// The shifts run one RAM entry per cycle through the single write port.
// Reset empties the list and sets the capacity to 256; the RAM is not cleared.
// A result waits in the output register while i_ready is low, and the next
// request can be taken meanwhile; its result then waits behind it.
`timescale 1ns / 1ps

module bounded_positional_list #(
    parameter int MAX_ENTRIES = bpl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_mode,
    input  logic [bpl_pkg::CNT_W-1:0]  i_position,
    input  logic [bpl_pkg::VALUE_W-1:0] i_item_value,
    input  logic [bpl_pkg::BYTES_W-1:0] i_byte_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic                       o_out_valid,
    output logic [bpl_pkg::VALUE_W-1:0] o_out_value,
    output logic [bpl_pkg::BYTES_W-1:0] o_out_byte_count,
    output logic [bpl_pkg::CNT_W-1:0]  o_list_length,
    output logic                       o_is_full,
    output logic                       o_is_empty,
    input  logic                       i_cfg_we,
    input  logic [bpl_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = bpl_pkg::CNT_W;

    bpl_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_cap;
    bpl_pkg::t_mode r_mode;
    bpl_pkg::t_status r_status;
    logic [CW-1:0] r_at;
    logic [bpl_pkg::VALUE_W-1:0] r_val_in;
    logic [bpl_pkg::BYTES_W-1:0] r_bytes_in;
    logic r_hit;
    logic [bpl_pkg::VALUE_W-1:0] r_out_val;
    logic [bpl_pkg::BYTES_W-1:0] r_out_bytes;

    logic r_up;
    logic r_rd_go;
    logic r_wr_go;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] r_wr_idx;
    logic [CW-1:0] r_last;

    logic r_o_valid;
    bpl_pkg::t_status r_o_status;
    logic r_o_hit;
    logic [bpl_pkg::VALUE_W-1:0] r_o_value;
    logic [bpl_pkg::BYTES_W-1:0] r_o_bytes;
    logic [CW-1:0] r_o_length;
    logic r_o_full;
    logic r_o_empty;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [bpl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [bpl_pkg::ENTRY_W-1:0] ram_rdata;

    logic accept;
    logic out_free;
    bpl_pkg::t_mode mode_in;
    logic is_ins;
    logic is_clear;
    logic [CW-1:0] cap_now;
    logic [CW-1:0] cap_cfg;
    logic [CW-1:0] at_calc;
    bpl_pkg::t_status status_calc;
    logic direct_ins;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign mode_in  = bpl_pkg::t_mode'(i_mode);
    assign cap_now  = bpl_pkg::eff_cap(r_cap, MAX_ENTRIES);
    assign cap_cfg  = bpl_pkg::eff_cap(i_cfg_data, MAX_ENTRIES);
    assign is_ins   = (mode_in == bpl_pkg::MODE_INS_FIRST) ||
                      (mode_in == bpl_pkg::MODE_INS_LAST) ||
                      (mode_in == bpl_pkg::MODE_INS_AT);
    assign is_clear = (mode_in == bpl_pkg::MODE_CLEAR);

    always_comb begin
        at_calc     = '0;
        status_calc = bpl_pkg::STAT_OK;
        unique case (mode_in)
            bpl_pkg::MODE_INS_FIRST: at_calc = '0;
            bpl_pkg::MODE_INS_LAST:  at_calc = r_count;
            bpl_pkg::MODE_INS_AT:    at_calc = (i_position > r_count) ? r_count : i_position;
            bpl_pkg::MODE_EXT_FIRST: at_calc = '0;
            bpl_pkg::MODE_EXT_LAST:  at_calc = r_count - CW'(1);
            bpl_pkg::MODE_EXT_AT,
            bpl_pkg::MODE_READ_AT:   at_calc = (i_position >= r_count) ?
                                               (r_count - CW'(1)) : i_position;
            bpl_pkg::MODE_CLEAR:     at_calc = '0;
            default:                 at_calc = '0;
        endcase
        if (is_ins) begin
            if (i_byte_count == '0) begin
                status_calc = bpl_pkg::STAT_ZERO_BYTES;
            end else if (r_count >= cap_now) begin
                status_calc = bpl_pkg::STAT_FULL;
            end
        end else if (!is_clear && (r_count == '0)) begin
            status_calc = bpl_pkg::STAT_EMPTY;
        end
    end

    assign direct_ins = accept && is_ins && (status_calc == bpl_pkg::STAT_OK) &&
                        (at_calc == r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpl_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((status_calc != bpl_pkg::STAT_OK) || is_clear || direct_ins) begin
                        n_state = bpl_pkg::ST_RESP;
                    end else if (is_ins) begin
                        n_state = bpl_pkg::ST_SHIFT;
                    end else begin
                        n_state = bpl_pkg::ST_RD_ENTRY;
                    end
                end
            end
            bpl_pkg::ST_RD_ENTRY: n_state = bpl_pkg::ST_CAPTURE;
            bpl_pkg::ST_CAPTURE: begin
                if ((r_mode == bpl_pkg::MODE_READ_AT) || (r_at == r_count - CW'(1))) begin
                    n_state = bpl_pkg::ST_RESP;
                end else begin
                    n_state = bpl_pkg::ST_SHIFT;
                end
            end
            bpl_pkg::ST_SHIFT: begin
                if (!r_rd_go && r_wr_go) begin
                    n_state = r_up ? bpl_pkg::ST_INS_WR : bpl_pkg::ST_RESP;
                end
            end
            bpl_pkg::ST_INS_WR: n_state = bpl_pkg::ST_RESP;
            bpl_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = bpl_pkg::ST_IDLE;
                end
            end
            default: n_state = bpl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == bpl_pkg::ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = AW'(r_wr_idx);
        ram_wdata = ram_rdata;
        ram_raddr = AW'(r_rd_idx);
        unique case (r_state)
            bpl_pkg::ST_IDLE: begin
                ram_we    = direct_ins;
                ram_waddr = AW'(at_calc);
                ram_wdata = {i_item_value, i_byte_count};
            end
            bpl_pkg::ST_RD_ENTRY: ram_raddr = AW'(r_at);
            bpl_pkg::ST_SHIFT:    ram_we = r_wr_go;
            bpl_pkg::ST_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_at);
                ram_wdata = {r_val_in, r_bytes_in};
            end
            bpl_pkg::ST_CAPTURE,
            bpl_pkg::ST_RESP: ram_we = 1'b0;
            default: ram_we = 1'b0;
        endcase
    end

    bpl_ram #(
        .WIDTH(bpl_pkg::ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_bpl_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bpl_pkg::ST_IDLE;
            r_count   <= '0;
            r_cap     <= bpl_pkg::CAP_RESET;
            r_rd_go   <= 1'b0;
            r_wr_go   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
                if (r_count > cap_cfg) begin
                    r_count <= cap_cfg;
                end
            end
            unique case (r_state)
                bpl_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_mode      <= mode_in;
                        r_status    <= status_calc;
                        r_at        <= at_calc;
                        r_val_in    <= i_item_value;
                        r_bytes_in  <= i_byte_count;
                        r_hit       <= 1'b0;
                        r_out_val   <= '0;
                        r_out_bytes <= '0;
                        if (is_clear) begin
                            r_count <= '0;
                        end else if (direct_ins) begin
                            r_count <= r_count + CW'(1);
                        end else if (is_ins && (status_calc == bpl_pkg::STAT_OK)) begin
                            r_up     <= 1'b1;
                            r_rd_go  <= 1'b1;
                            r_rd_idx <= r_count - CW'(1);
                            r_last   <= at_calc;
                        end
                    end
                end
                bpl_pkg::ST_RD_ENTRY: begin
                    r_hit <= 1'b0;
                end
                bpl_pkg::ST_CAPTURE: begin
                    r_hit       <= 1'b1;
                    r_out_val   <= ram_rdata[bpl_pkg::ENTRY_W-1:bpl_pkg::BYTES_W];
                    r_out_bytes <= ram_rdata[bpl_pkg::BYTES_W-1:0];
                    if (r_mode != bpl_pkg::MODE_READ_AT) begin
                        if (r_at == r_count - CW'(1)) begin
                            r_count <= r_count - CW'(1);
                        end else begin
                            r_up     <= 1'b0;
                            r_rd_go  <= 1'b1;
                            r_rd_idx <= r_at + CW'(1);
                            r_last   <= r_count - CW'(1);
                        end
                    end
                end
                bpl_pkg::ST_SHIFT: begin
                    if (r_rd_go) begin
                        r_wr_go  <= 1'b1;
                        r_wr_idx <= r_up ? (r_rd_idx + CW'(1)) : (r_rd_idx - CW'(1));
                        if (r_rd_idx == r_last) begin
                            r_rd_go <= 1'b0;
                        end else begin
                            r_rd_idx <= r_up ? (r_rd_idx - CW'(1)) : (r_rd_idx + CW'(1));
                        end
                    end else begin
                        r_wr_go <= 1'b0;
                        if (r_wr_go && !r_up) begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                bpl_pkg::ST_INS_WR: begin
                    r_count <= r_count + CW'(1);
                end
                bpl_pkg::ST_RESP: begin
                    r_wr_go <= 1'b0;
                end
                default: r_rd_go <= 1'b0;
            endcase
            if ((r_state == bpl_pkg::ST_RESP) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == bpl_pkg::ST_RESP) && out_free) begin
            r_o_status <= r_status;
            r_o_hit    <= r_hit;
            r_o_value  <= r_out_val;
            r_o_bytes  <= r_out_bytes;
            r_o_length <= r_count;
            r_o_full   <= (r_count == cap_now);
            r_o_empty  <= (r_count == '0);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_out_valid      = r_o_hit;
    assign o_out_value      = r_o_value;
    assign o_out_byte_count = r_o_bytes;
    assign o_list_length    = r_o_length;
    assign o_is_full        = r_o_full;
    assign o_is_empty       = r_o_empty;

endmodule

// File: hw/rtl/bpl_checker.sv
// Port-level checker of the bounded positional list and its bind statement.
`timescale 1ns / 1ps
`include "bounded_positional_list_macros.svh"

module bpl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [1:0]                  o_status,
    input logic                        o_out_valid,
    input logic [bpl_pkg::VALUE_W-1:0] o_out_value,
    input logic [bpl_pkg::BYTES_W-1:0] o_out_byte_count,
    input logic [bpl_pkg::CNT_W-1:0]   o_list_length,
    input logic                        o_is_full,
    input logic                        o_is_empty
);

    `BPL_ASSERT_SAME(a_no_entry_zero, i_clk, i_rst_n, o_valid && !o_out_valid,
        (o_out_value == '0) && (o_out_byte_count == '0), "Returned fields set without an entry")

    `BPL_ASSERT_SAME(a_empty_flag, i_clk, i_rst_n, o_valid,
        o_is_empty == (o_list_length == '0), "Empty flag disagrees with the length")

    `BPL_ASSERT_SAME(a_entry_ok, i_clk, i_rst_n, o_valid && o_out_valid,
        (o_status == bpl_pkg::STAT_OK) && !o_is_full || (o_status == bpl_pkg::STAT_OK),
        "Returned entry without an ok status")

    `BPL_ASSERT_SAME(a_full_refusal, i_clk, i_rst_n, o_valid && (o_status == bpl_pkg::STAT_FULL),
        o_is_full && !o_is_empty, "Full refusal while the list is not full")

    `BPL_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_valid && o_ready,
        !o_ready, "Request taken while the previous one is still in work")

endmodule

bind bounded_positional_list bpl_checker u_bpl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_status        (o_status),
    .o_out_valid     (o_out_valid),
    .o_out_value     (o_out_value),
    .o_out_byte_count(o_out_byte_count),
    .o_list_length   (o_list_length),
    .o_is_full       (o_is_full),
    .o_is_empty      (o_is_empty)
);

// File: tb/sv/bounded_positional_list_tb.sv
// Self-checking testbench of the bounded positional list with a queue-based list predictor.
`timescale 1ns / 1ps

module bounded_positional_list_tb;
    import bpl_pkg::*;

    localparam int DEPTH       = MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 300;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BYTES_W-1:0] bytes;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic               hit;
        logic [VALUE_W-1:0] value;
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   length;
        logic               full;
        logic               empty;
    } t_outcome;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode           = MODE_CLEAR;
    logic [CNT_W-1:0]   i_position       = '0;
    logic [VALUE_W-1:0] i_item_value     = '0;
    logic [BYTES_W-1:0] i_byte_count     = '0;
    logic               o_valid;
    logic               i_ready          = 1'b0;
    logic [1:0]         o_status;
    logic               o_out_valid;
    logic [VALUE_W-1:0] o_out_value;
    logic [BYTES_W-1:0] o_out_byte_count;
    logic [CNT_W-1:0]   o_list_length;
    logic               o_is_full;
    logic               o_is_empty;
    logic               i_cfg_we         = 1'b0;
    logic [CNT_W-1:0]   i_cfg_data       = '0;

    t_entry           held_entries[$];
    t_outcome         awaited_results[$];
    logic [CNT_W-1:0] capacity_reg     = CAP_RESET;
    int               mismatch_count   = 0;
    int               cycle_count      = 0;
    int               hold_request     = 0;
    int               hold_left        = 0;
    bit               sender_idles     = 1'b1;
    bit               receiver_idles   = 1'b1;

    bounded_positional_list uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .i_byte_count     (i_byte_count),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_out_valid      (o_out_valid),
        .o_out_value      (o_out_value),
        .o_out_byte_count (o_out_byte_count),
        .o_list_length    (o_list_length),
        .o_is_full        (o_is_full),
        .o_is_empty       (o_is_empty),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int capacity_limit();
        if (capacity_reg == '0) begin
            return 1;
        end
        if (int'(capacity_reg) > DEPTH) begin
            return DEPTH;
        end
        return int'(capacity_reg);
    endfunction

    function automatic void trim_list();
        while (held_entries.size() > capacity_limit()) begin
            void'(held_entries.pop_back());
        end
    endfunction

    function automatic t_outcome list_apply(input t_mode mode, input logic [CNT_W-1:0] pos,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [BYTES_W-1:0] bytes);
        t_outcome res;
        t_entry   fresh;
        int       len;
        int       at;
        res = '0;
        res.status = STAT_OK;
        trim_list();
        len = held_entries.size();
        case (mode)
            MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_AT: begin
                if (bytes == '0) begin
                    res.status = STAT_ZERO_BYTES;
                end else if (len >= capacity_limit()) begin
                    res.status = STAT_FULL;
                end else begin
                    if (mode == MODE_INS_FIRST) begin
                        at = 0;
                    end else if (mode == MODE_INS_LAST) begin
                        at = len;
                    end else begin
                        at = (int'(pos) > len) ? len : int'(pos);
                    end
                    fresh.value = value;
                    fresh.bytes = bytes;
                    held_entries.insert(at, fresh);
                end
            end
            MODE_CLEAR: begin
                held_entries.delete();
            end
            default: begin
                if (len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    if (mode == MODE_EXT_FIRST) begin
                        at = 0;
                    end else if (mode == MODE_EXT_LAST) begin
                        at = len - 1;
                    end else begin
                        at = (int'(pos) >= len) ? len - 1 : int'(pos);
                    end
                    res.hit   = 1'b1;
                    res.value = held_entries[at].value;
                    res.bytes = held_entries[at].bytes;
                    if (mode != MODE_READ_AT) begin
                        held_entries.delete(at);
                    end
                end
            end
        endcase
        res.length = CNT_W'(held_entries.size());
        res.full   = (held_entries.size() == capacity_limit());
        res.empty  = (held_entries.size() == 0);
        return res;
    endfunction

    function automatic string outcome_text(input t_outcome o);
        return $sformatf("status=%0d hit=%0b value=%h bytes=%h length=%0d full=%0b empty=%0b",
                         o.status, o.hit, o.value, o.bytes, o.length, o.full, o.empty);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(receiver_idles && $urandom_range(0, 99) < 10);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            got.status = t_status'(o_status);
            got.hit    = o_out_valid;
            got.value  = o_out_value;
            got.bytes  = o_out_byte_count;
            got.length = o_list_length;
            got.full   = o_is_full;
            got.empty  = o_is_empty;
            if (awaited_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("Unexpected result transfer: %s", outcome_text(got));
                end
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10) begin
                        $display("Result mismatch at cycle %0d", cycle_count);
                        $display("  expected %s", outcome_text(want));
                        $display("  actual   %s", outcome_text(got));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(input t_mode mode, input logic [CNT_W-1:0] pos,
                                input logic [VALUE_W-1:0] value,
                                input logic [BYTES_W-1:0] bytes);
        while (sender_idles && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_position   <= pos;
        i_item_value <= value;
        i_byte_count <= bytes;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        awaited_results.push_back(list_apply(mode, pos, value, bytes));
    endtask

    task automatic send_random(input int ins_pct);
        int               pick;
        t_mode            mode;
        logic [CNT_W-1:0] pos;
        logic [BYTES_W-1:0] bytes;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) begin
            mode = t_mode'($urandom_range(0, 2));
        end else if (pick < 97) begin
            mode = t_mode'($urandom_range(3, 6));
        end else begin
            mode = MODE_CLEAR;
        end
        if ($urandom_range(0, 9) < 7) begin
            pos = CNT_W'($urandom_range(0, held_entries.size()));
        end else begin
            pos = CNT_W'($urandom_range(0, 511));
        end
        case ($urandom_range(0, 19))
            0: bytes = '0;
            1: bytes = '1;
            default: bytes = BYTES_W'($urandom_range(1, 65535));
        endcase
        send_request(mode, pos, $urandom, bytes);
    endtask

    task automatic finish_phase();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        finish_phase();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_reg = cap;
        trim_list();
    endtask

    task automatic test_basic_operations();
        write_capacity(9'd256);
        send_request(MODE_EXT_FIRST, 9'd0, '0, '0);
        send_request(MODE_EXT_LAST, 9'd0, '0, '0);
        send_request(MODE_EXT_AT, 9'd511, '0, '1);
        send_request(MODE_READ_AT, 9'd0, '0, '0);
        send_request(MODE_INS_FIRST, 9'd0, 32'hFFFF_FFFF, '0);
        send_request(MODE_INS_FIRST, 9'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(MODE_INS_LAST, 9'd511, 32'h0, 16'h0001);
        send_request(MODE_INS_AT, 9'd511, 32'h1234_5678, 16'h8000);
        send_request(MODE_INS_AT, 9'd0, 32'h8000_0000, 16'h7FFF);
        send_request(MODE_INS_AT, 9'd1, $urandom, 16'h00FF);
        send_request(MODE_READ_AT, 9'd0, '0, '0);
        send_request(MODE_READ_AT, 9'd511, '0, '0);
        send_request(MODE_READ_AT, 9'd256, '0, '0);
        send_request(MODE_EXT_AT, 9'd300, '0, '0);
        send_request(MODE_EXT_AT, 9'd1, '0, '0);
        send_request(MODE_EXT_FIRST, 9'd0, '0, '0);
        send_request(MODE_EXT_LAST, 9'd0, '0, '0);
        send_request(MODE_INS_LAST, 9'd0, $urandom, 16'h0042);
        send_request(MODE_CLEAR, 9'd0, '0, '0);
        send_request(MODE_CLEAR, 9'd0, '0, '0);
        finish_phase();
    endtask

    task automatic test_capacity_limits();
        write_capacity(9'd0);
        send_request(MODE_INS_LAST, 9'd0, $urandom, 16'h0010);
        send_request(MODE_INS_FIRST, 9'd0, $urandom, 16'h0020);
        send_request(MODE_INS_AT, 9'd0, $urandom, '0);
        send_request(MODE_READ_AT, 9'd511, '0, '0);
        send_request(MODE_EXT_LAST, 9'd0, '0, '0);
        write_capacity(9'd1);
        send_request(MODE_INS_AT, 9'd5, $urandom, 16'h0003);
        send_request(MODE_INS_LAST, 9'd0, $urandom, 16'h0004);
        write_capacity(9'd4);
        repeat (4) send_request(MODE_INS_LAST, 9'd0, $urandom, 16'h0100);
        write_capacity(9'd2);
        send_request(MODE_READ_AT, 9'd3, '0, '0);
        send_request(MODE_EXT_AT, 9'd2, '0, '0);
        send_request(MODE_CLEAR, 9'd0, '0, '0);
        finish_phase();
    endtask

    task automatic test_random_small_lists();
        repeat (4) begin
            write_capacity(CNT_W'($urandom_range(2, 12)));
            repeat (45) send_random(55);
        end
        finish_phase();
    endtask

    task automatic test_output_backpressure();
        write_capacity(9'd6);
        hold_request = 400;
        repeat (30) send_random(60);
        finish_phase();
    endtask

    task automatic test_back_to_back();
        write_capacity(9'd20);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (100) send_random(50);
        finish_phase();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_full_depth();
        write_capacity(9'd511);
        while (held_entries.size() < capacity_limit()) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(MODE_INS_AT, CNT_W'($urandom_range(0, held_entries.size())),
                             $urandom, BYTES_W'($urandom_range(1, 65535)));
            end else begin
                send_request(MODE_INS_LAST, '0, $urandom, BYTES_W'($urandom_range(1, 65535)));
            end
        end
        send_request(MODE_INS_FIRST, 9'd0, $urandom, 16'hFFFF);
        send_request(MODE_INS_AT, 9'd128, $urandom, 16'h0001);
        send_request(MODE_READ_AT, 9'd255, '0, '0);
        send_request(MODE_EXT_FIRST, 9'd0, '0, '0);
        send_request(MODE_INS_FIRST, 9'd0, $urandom, 16'hFFFF);
        repeat (20) send_random(40);
        write_capacity(9'd1);
        send_request(MODE_READ_AT, 9'd0, '0, '0);
        send_request(MODE_INS_LAST, 9'd0, $urandom, 16'h0005);
        write_capacity(9'd256);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_operations();
        test_capacity_limits();
        test_random_small_lists();
        test_output_backpressure();
        test_back_to_back();
        test_full_depth();
        finish_phase();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bpl_pkg.sv
hw/rtl/bpl_ram.sv
hw/rtl/bounded_positional_list.sv
hw/rtl/bpl_checker.sv
tb/sv/bounded_positional_list_tb.sv
